@@ rtl/dsdf_pkg.sv @@
// shared types, constants and conversion step for the digit frame formatter
package dsdf_pkg;

  localparam int VALUE_W        = 32;
  localparam int DEC_W          = 5;
  localparam int CD_W           = DEC_W + 1;
  localparam int BCD_DIGITS     = 10;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int BITS_PER_STAGE = 4;
  localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;
  localparam int FRAME_W        = 12;

  localparam logic [3:0] CODE_MINUS = 4'hB;
  localparam logic [3:0] CODE_BLANK = 4'hF;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // one value in flight through the binary to decimal conversion
  typedef struct packed {
    logic [VALUE_W-1:0]     bin;
    bcd_t                   bcd;
    logic                   negative;
    logic signed [DEC_W-1:0] decimals;
  } conv_t;

  // one shift-add-3 step: correct every digit, then shift in the next binary bit
  function automatic conv_t dabble_step(conv_t d);
    conv_t            r;
    bcd_t             b;
    logic [BCD_W-1:0] flat;
    r = d;
    b = d.bcd;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (b[k] >= 4'd5) begin
        b[k] = b[k] + 4'd3;
      end
    end
    flat  = b;
    r.bcd = {flat[BCD_W-2:0], d.bin[VALUE_W-1]};
    r.bin = {d.bin[VALUE_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

@@ rtl/dsdf_if.sv @@
// channel interfaces for input values and output frames
interface dsdf_in_if
  import dsdf_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VALUE_W-1:0] value;
  logic signed [DEC_W-1:0]   decimals;

  modport source (output valid, output value, output decimals, input ready);
  modport sink (input valid, input value, input decimals, output ready);
endinterface

interface dsdf_out_if
  import dsdf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_word;
  logic               last;

  modport source (output valid, output frame_word, output last, input ready);
  modport sink (input valid, input frame_word, input last, output ready);
endinterface

@@ rtl/signed_decimal_digit_frame_formatter.sv @@
// each value passes input register, dabble stages, serializer state and frame register
// one frame a cycle while output is ready; the next value loads as the last frame is emitted
// the conversion pipeline takes a new value every cycle and holds items under stall
// reset clears valid bits and the serializer busy flag only; payload registers are not reset
module signed_decimal_digit_frame_formatter
  import dsdf_pkg::*;
#(
  parameter int DIGIT_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dsdf_in_if.sink           in_i,
  dsdf_out_if.source        out_o
);

  // pipeline links: index 0 is the input register, index k+1 the output of dabble stage k
  logic  stg_valid [DABBLE_STAGES+1];
  logic  stg_ready [DABBLE_STAGES+1];
  conv_t stg_data  [DABBLE_STAGES+1];

  // input register: sign split and magnitude, taken as unsigned so the most negative works
  logic  in_valid_q;
  conv_t in_data_q;
  conv_t in_data_d;
  logic  in_ready;

  assign in_ready   = !in_valid_q || stg_ready[0];
  assign in_i.ready = in_ready;

  always_comb begin
    in_data_d.negative = in_i.value[VALUE_W-1];
    in_data_d.bin      = in_i.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_i.value))
                                               : VALUE_W'(in_i.value);
    in_data_d.bcd      = '0;
    in_data_d.decimals = in_i.decimals;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_data_q <= in_data_d;
    end
  end

  assign stg_valid[0] = in_valid_q;
  assign stg_data[0]  = in_data_q;

  // double dabble, four bits per stage, binary magnitude in, ten decimal digits out
  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    dsdf_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .data_i  (stg_data[g]),
      .ready_o (stg_ready[g]),
      .valid_o (stg_valid[g+1]),
      .data_o  (stg_data[g+1]),
      .ready_i (stg_ready[g+1])
    );
  end

  // frame generation: one transaction per digit position, least significant first
  dsdf_serializer #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (stg_valid[DABBLE_STAGES]),
    .data_i       (stg_data[DABBLE_STAGES]),
    .ready_o      (stg_ready[DABBLE_STAGES]),
    .valid_o      (out_o.valid),
    .frame_word_o (out_o.frame_word),
    .last_o       (out_o.last),
    .ready_i      (out_o.ready)
  );

endmodule

@@ rtl/dsdf_dabble_stage.sv @@
// one pipeline stage of the binary to decimal conversion
module dsdf_dabble_stage
  import dsdf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  conv_t data_i,
  output logic  ready_o,
  output logic  valid_o,
  output conv_t data_o,
  input  logic  ready_i
);

  logic  valid_q;
  conv_t data_q;
  conv_t data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/dsdf_serializer.sv @@
// walks the decimal digits of one value and emits one display frame per cycle while the output is ready
module dsdf_serializer
  import dsdf_pkg::*;
#(
  parameter int DIGIT_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  conv_t              data_i,
  output logic               ready_o,
  output logic               valid_o,
  output logic [FRAME_W-1:0] frame_word_o,
  output logic               last_o,
  input  logic               ready_i
);

  localparam int IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int SelW = $clog2(BCD_DIGITS);

  logic                   busy_q, busy_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  bcd_t                   bcd_q, bcd_d;
  logic                   minus_q, minus_d;
  logic signed [CD_W-1:0] cd_q, cd_d;

  logic               out_valid_q;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               last_q;

  logic                  out_free, emit, last_frame, load;
  logic [BCD_DIGITS-1:0] nz_above;
  logic                  show, point, use_minus;
  logic [3:0]            digit, code, pos;
  logic [SelW-1:0]       sel;

  assign out_free   = !out_valid_q || ready_i;
  assign emit       = busy_q && out_free;
  assign last_frame = (idx_q == IdxW'(DIGIT_COUNT - 1));
  assign ready_o    = !busy_q || (emit && last_frame);
  assign load       = ready_o && valid_i;
  assign sel        = SelW'(idx_q);

  // remaining quotient at digit k is nonzero when any digit from k upward is
  always_comb begin
    nz_above[BCD_DIGITS-1] = (bcd_q[BCD_DIGITS-1] != 4'd0);
    for (int k = BCD_DIGITS - 2; k >= 0; k--) begin
      nz_above[k] = nz_above[k+1] || (bcd_q[k] != 4'd0);
    end
  end

  always_comb begin
    digit     = bcd_q[sel];
    show      = nz_above[sel] || !cd_q[CD_W-1];
    point     = (cd_q == '0);
    use_minus = !show && minus_q;
    if (show) begin
      code = digit;
    end else if (minus_q) begin
      code = CODE_MINUS;
    end else begin
      code = CODE_BLANK;
    end
    pos     = 4'(idx_q) + 4'd1;
    frame_d = {pos, point, 3'b000, code};
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    bcd_d   = bcd_q;
    minus_d = minus_q;
    cd_d    = cd_q;
    if (emit) begin
      idx_d = idx_q + 1'b1;
      cd_d  = cd_q - CD_W'(1);
      if (use_minus) begin
        minus_d = 1'b0;
      end
      if (last_frame) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      bcd_d   = data_i.bcd;
      minus_d = data_i.negative;
      cd_d    = CD_W'(data_i.decimals);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (out_free) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    bcd_q   <= bcd_d;
    minus_q <= minus_d;
    cd_q    <= cd_d;
    if (emit) begin
      frame_q <= frame_d;
      last_q  <= last_frame;
    end
  end

  assign valid_o      = out_valid_q;
  assign frame_word_o = frame_q;
  assign last_o       = last_q;

endmodule

@@ tb/dsdf_frame_checker.sv @@
`timescale 1ns / 1ps
// frame checker: predicts the display frames of each accepted value and compares the frame stream
module dsdf_frame_checker
  import dsdf_pkg::*;
#(
  parameter int DIGIT_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [DEC_W-1:0]    decimals_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [FRAME_W-1:0]  frame_word_i,
  input  logic                last_i,
  output int                  mismatches_o,
  output int                  frames_pending_o
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame_word;
    logic               last;
  } frame_t;

  frame_t frames_due[$];
  int     mismatches = 0;
  int     frames_pending = 0;

  assign mismatches_o     = mismatches;
  assign frames_pending_o = frames_pending;

  // one frame per digit position, least significant first
  function automatic void predict_frames(input logic [VALUE_W-1:0] value,
                                         input logic signed [DEC_W-1:0] decimals);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digit;
    logic [3:0]         code;
    logic               minus_pending;
    logic               point;
    int                 countdown;
    frame_t             f;
    minus_pending = value[VALUE_W-1];
    mag           = minus_pending ? (32'd0 - value) : value;
    countdown     = decimals;
    for (int pos = 1; pos <= DIGIT_COUNT; pos++) begin
      digit = 4'(mag % 32'd10);
      point = (countdown == 0);
      if (mag != 0 || digit != 0 || countdown >= 0) begin
        code = digit;
      end else if (minus_pending) begin
        minus_pending = 1'b0;
        code          = CODE_MINUS;
      end else begin
        code = CODE_BLANK;
      end
      f.frame_word = {4'(pos), point, 3'b000, code};
      f.last       = (pos == DIGIT_COUNT);
      frames_due.push_back(f);
      mag       = mag / 32'd10;
      countdown = countdown - 1;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        predict_frames(value_i, decimals_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (frames_due.size() == 0) begin
          $error("frame_word: expected none, got %h (last %b)", frame_word_i, last_i);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (frame_word_i !== want.frame_word) begin
            $error("frame_word: expected %h, got %h", want.frame_word, frame_word_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_i);
            mismatches++;
          end
        end
      end
      frames_pending = frames_due.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, value stimulus, frame sink and verdict for the digit frame formatter
module tb_top;
  import dsdf_pkg::*;

  localparam int DIGIT_COUNT  = 8;
  localparam int IDLE_PCT     = 22;    // percent of cycles each side sits idle
  localparam int HOLD_CYCLES  = 300;   // long back-pressure stretch on the frame side
  localparam int STALL_LIMIT  = 4000;  // cycles with no transaction before giving up
  localparam int RANDOM_ITEMS = 220;
  localparam int TAIL_CYCLES  = 20;    // time after the drain for stray frames to show up

  logic clk_i;
  logic rst_ni;

  // no_idle: both sides run flat out; drain_hold_req: ask the sink for a long stall
  logic no_idle        = 1'b0;
  logic drain_hold_req = 1'b0;

  int mismatches;
  int frames_pending;
  int quiet_cycles = 0;

  dsdf_in_if  in_if ();
  dsdf_out_if out_if ();

  signed_decimal_digit_frame_formatter #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  dsdf_frame_checker #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_i      (in_if.ready),
    .value_i         (in_if.value),
    .decimals_i      (in_if.decimals),
    .out_valid_i     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .frame_word_i    (out_if.frame_word),
    .last_i          (out_if.last),
    .mismatches_o    (mismatches),
    .frames_pending_o(frames_pending)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: count cycles in which neither channel completes a transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // frame sink: random ready, except during the no-idle stretch and the long hold
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (drain_hold_req) begin
        // hold off long enough for the pipeline to fill and block the value side
        drain_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one value; random idle cycles before it, then wait for the transaction
  task automatic send_value(input logic signed [VALUE_W-1:0] value,
                            input logic signed [DEC_W-1:0] decimals);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.value    <= value;
    in_if.decimals <= decimals;
    // ready is read right after the edge, so it still shows the value the edge saw
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  initial begin
    logic signed [VALUE_W-1:0] v;
    logic signed [DEC_W-1:0]   d;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.value    = '0;
    in_if.decimals = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero: blank with no decimals, digits once decimals are asked for
    send_value(0, -1);
    send_value(0, 0);
    send_value(0, 8);
    send_value(0, -16);
    // small values, minus placement, point on a leading zero
    send_value(1, -1);
    send_value(-1, -1);
    send_value(-1, 0);
    send_value(-5, 1);
    send_value(100, -1);
    send_value(-12345, 2);
    send_value(-7, 7);
    send_value(7, 8);
    // extremes of the value, most negative one included
    send_value(32'sh7FFFFFFF, -1);
    send_value(32'sh80000000, -1);
    send_value(32'sh80000000, 3);
    // digit counts around the position count: upper digits or the minus may fall off
    send_value(123456789, 2);
    send_value(-100000000, -1);
    send_value(-99999999, -1);
    send_value(-9999999, -1);
    send_value(10000000, 3);
    // decimals outside the documented range
    send_value(42, 15);
    send_value(-42, -16);
    send_value(-42, -2);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 60 && n < 110);
      if (n == 160) begin
        drain_hold_req = 1'b1;
      end
      case ($urandom_range(9))
        0, 1, 2: v = $urandom_range(1998) - 999;
        3, 4: begin
          v = $urandom_range(99999999);
          if ($urandom_range(1)) v = -v;
        end
        5: v = $urandom_range(9999999);
        6: begin
          case ($urandom_range(4))
            0: v = 32'sh7FFFFFFF;
            1: v = 32'sh80000000;
            2: v = 32'sh80000001;
            3: v = -1;
            default: v = 0;
          endcase
        end
        default: v = $urandom;
      endcase
      // mostly the documented -1..8, sometimes any 5-bit pattern
      if ($urandom_range(9) < 8) begin
        d = DEC_W'($urandom_range(9) - 1);
      end else begin
        d = DEC_W'($urandom_range(31));
      end
      send_value(v, d);
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;
    @(posedge clk_i);

    // drain every expected frame, then give stray frames time to show up
    wait (frames_pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ signed_decimal_digit_frame_formatter.f @@
rtl/dsdf_pkg.sv
rtl/dsdf_if.sv
rtl/dsdf_dabble_stage.sv
rtl/dsdf_serializer.sv
rtl/signed_decimal_digit_frame_formatter.sv
tb/dsdf_frame_checker.sv
tb/tb_top.sv
